// ===== hdl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

   localparam int COEF_W        = 16;
   localparam int DISC_W        = 34;
   localparam int ROOT_W        = 40;
   localparam int DEN_W         = 17;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic signed [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
   localparam logic signed [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_TWO    = 2'd0,
      ST_DOUBLE = 2'd1,
      ST_NONE   = 2'd2,
      ST_NOTQ   = 2'd3
   } qrs_status_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [DISC_W-1:0] disc;
      qrs_status_type           status;
   } qrs_side_type;

endpackage

`default_nettype wire

// ===== hdl/qrs_front.sv =====
// ----------------------------------------------------------------------------
// qrs_front
// Two stages: products b*b and a*c, then discriminant and classification.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front
   import qrs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [COEF_W-1:0] in_a,
   input  wire logic signed [COEF_W-1:0] in_b,
   input  wire logic signed [COEF_W-1:0] in_c,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output qrs_side_type                  out_side,
   output logic [DISC_W-1:0]             out_d
);

   logic                             v1_ff;
   logic                             rdy1;
   logic signed [COEF_W-1:0]         a1_ff;
   logic signed [COEF_W-1:0]         b1_ff;
   logic signed [2*COEF_W-1:0]       bb1_ff;
   logic signed [2*COEF_W-1:0]       ac1_ff;
   logic                             v2_ff;
   qrs_side_type                     side2_ff;
   qrs_side_type                     side2_in;
   logic [DISC_W-1:0]                d2_ff;
   logic [DISC_W-1:0]                d2_in;
   logic signed [DISC_W-1:0]         delta;

   assign in_ready = !v1_ff || rdy1;
   assign rdy1     = !v2_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (in_ready) v1_ff <= in_valid;
         if (rdy1)     v2_ff <= v1_ff;
      end
      if (in_ready && in_valid) begin
         a1_ff  <= in_a;
         b1_ff  <= in_b;
         bb1_ff <= in_b * in_b;
         ac1_ff <= in_a * in_c;
      end
      if (rdy1 && v1_ff) begin
         side2_ff <= side2_in;
         d2_ff    <= d2_in;
      end
   end

   always_comb begin
      delta = DISC_W'(bb1_ff) - (DISC_W'(ac1_ff) <<< 2);
      side2_in.coef_a = a1_ff;
      side2_in.coef_b = b1_ff;
      side2_in.disc   = delta;
      d2_in           = '0;
      if (a1_ff == '0) begin
         side2_in.status = ST_NOTQ;
         side2_in.disc   = '0;
      end else if (delta < 0) begin
         side2_in.status = ST_NONE;
      end else if (delta == '0) begin
         side2_in.status = ST_DOUBLE;
      end else begin
         side2_in.status = ST_TWO;
         d2_in           = delta;
      end
   end

   assign out_valid = v2_ff;
   assign out_side  = side2_ff;
   assign out_d     = d2_ff;

endmodule

`default_nettype wire

// ===== hdl/qrs_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of the restoring square root; hands its state to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell
   import qrs_pkg::*;
#(
   parameter int RW = 33
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire qrs_side_type  in_side,
   input  wire logic [DISC_W-1:0] in_d,
   input  wire logic [RW+1:0] in_rem,
   input  wire logic [RW-1:0] in_root,
   output logic               out_valid,
   input  wire logic          out_ready,
   output qrs_side_type       out_side,
   output logic [DISC_W-1:0]  out_d,
   output logic [RW+1:0]      out_rem,
   output logic [RW-1:0]      out_root
);

   logic              v_ff;
   qrs_side_type      side_ff;
   logic [DISC_W-1:0] d_ff;
   logic [RW+1:0]     rem_ff;
   logic [RW+1:0]     rem_in;
   logic [RW-1:0]     root_ff;
   logic [RW-1:0]     root_in;
   logic [RW+3:0]     remsh;
   logic [RW+3:0]     trial;
   logic [RW+3:0]     diff;
   logic              ge;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      remsh   = {in_rem, in_d[DISC_W-1 -: 2]};
      trial   = (RW+4)'({in_root, 2'b01});
      diff    = remsh - trial;
      ge      = remsh >= trial;
      rem_in  = ge ? diff[RW+1:0] : remsh[RW+1:0];
      root_in = {in_root[RW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         side_ff <= in_side;
         d_ff    <= in_d << 2;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = v_ff;
   assign out_side  = side_ff;
   assign out_d     = d_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

`default_nettype wire

// ===== hdl/qrs_div_cell.sv =====
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of two restoring dividers sharing one divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell
   import qrs_pkg::*;
#(
   parameter int NW = 34
)
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire qrs_side_type              in_side,
   input  wire logic [DEN_W-1:0]          in_den,
   input  wire logic [1:0]                in_neg,
   input  wire logic [1:0][NW-1:0]        in_n,
   input  wire logic [1:0][DEN_W-1:0]     in_p,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output qrs_side_type                   out_side,
   output logic [DEN_W-1:0]               out_den,
   output logic [1:0]                     out_neg,
   output logic [1:0][NW-1:0]             out_n,
   output logic [1:0][DEN_W-1:0]          out_p
);

   logic                      v_ff;
   qrs_side_type              side_ff;
   logic [DEN_W-1:0]          den_ff;
   logic [1:0]                neg_ff;
   logic [1:0][NW-1:0]        n_ff;
   logic [1:0][NW-1:0]        n_in;
   logic [1:0][DEN_W-1:0]     p_ff;
   logic [1:0][DEN_W-1:0]     p_in;
   logic [1:0][DEN_W:0]       t;
   logic [1:0]                ge;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         t[l]    = {in_p[l], in_n[l][NW-1]};
         ge[l]   = t[l] >= {1'b0, in_den};
         p_in[l] = ge[l] ? DEN_W'(t[l] - {1'b0, in_den}) : t[l][DEN_W-1:0];
         n_in[l] = {in_n[l][NW-2:0], ge[l]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         side_ff <= in_side;
         den_ff  <= in_den;
         neg_ff  <= in_neg;
         n_ff    <= n_in;
         p_ff    <= p_in;
      end
   end

   assign out_valid = v_ff;
   assign out_side  = side_ff;
   assign out_den   = den_ff;
   assign out_neg   = neg_ff;
   assign out_n     = n_ff;
   assign out_p     = p_ff;

endmodule

`default_nettype wire

// ===== hdl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Discriminant and real roots of a*x^2 + b*x + c in signed fixed point.
// ----------------------------------------------------------------------------
// The pipeline holds two front stages, 17 + FRAC_BITS root cells, one set-up
// stage, 18 + FRAC_BITS divider cells and the output register. One item per
// cycle; each stage holds when the next one is full and stalled. Synchronous
// reset empties every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_root_solver
   import qrs_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [COEF_W-1:0] req_coef_a,
   input  wire logic signed [COEF_W-1:0] req_coef_b,
   input  wire logic signed [COEF_W-1:0] req_coef_c,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [ROOT_W-1:0]      rsp_root_plus,
   output logic signed [ROOT_W-1:0]      rsp_root_minus,
   output logic signed [DISC_W-1:0]      rsp_discriminant,
   output logic [1:0]                    rsp_root_status
);

   localparam int NS   = 17 + FRAC_BITS;
   localparam int RW   = 17 + FRAC_BITS;
   localparam int NW   = 18 + FRAC_BITS;
   localparam int NUMW = NW + 1;
   localparam int EW   = NW + ROOT_W;

   logic                      sq_valid [0:NS];
   logic                      sq_ready [0:NS];
   qrs_side_type              sq_side  [0:NS];
   logic [DISC_W-1:0]         sq_d     [0:NS];
   logic [RW+1:0]             sq_rem   [0:NS];
   logic [RW-1:0]             sq_root  [0:NS];

   logic                      dv_valid [0:NW];
   logic                      dv_ready [0:NW];
   qrs_side_type              dv_side  [0:NW];
   logic [DEN_W-1:0]          dv_den   [0:NW];
   logic [1:0]                dv_neg   [0:NW];
   logic [1:0][NW-1:0]        dv_n     [0:NW];
   logic [1:0][DEN_W-1:0]     dv_p     [0:NW];

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_a      (req_coef_a),
      .in_b      (req_coef_b),
      .in_c      (req_coef_c),
      .out_valid (sq_valid[0]),
      .out_ready (sq_ready[0]),
      .out_side  (sq_side[0]),
      .out_d     (sq_d[0])
   );

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar i = 0; i < NS; i++) begin : g_sqrt
      qrs_sqrt_cell #(.RW(RW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[i]),
         .in_ready  (sq_ready[i]),
         .in_side   (sq_side[i]),
         .in_d      (sq_d[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .out_valid (sq_valid[i+1]),
         .out_ready (sq_ready[i+1]),
         .out_side  (sq_side[i+1]),
         .out_d     (sq_d[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1])
      );
   end

   // set-up: numerators -b*2^F +/- s, magnitudes, signs and |2a|
   logic                       su_v_ff;
   qrs_side_type               su_side_ff;
   logic [DEN_W-1:0]           su_den_ff;
   logic [DEN_W-1:0]           su_den_in;
   logic [1:0]                 su_neg_ff;
   logic [1:0]                 su_neg_in;
   logic [1:0][NW-1:0]         su_n_ff;
   logic [1:0][NW-1:0]         su_n_in;
   logic signed [NUMW-1:0]     nb;
   logic signed [NUMW-1:0]     sx;
   logic signed [NUMW-1:0]     num [0:1];
   logic signed [NUMW-1:0]     mag [0:1];
   logic signed [COEF_W:0]     a_abs;
   logic                       a_neg;

   assign sq_ready[NS] = !su_v_ff || dv_ready[0];

   always_comb begin
      a_neg  = sq_side[NS].coef_a < 0;
      a_abs  = (COEF_W+1)'(sq_side[NS].coef_a);
      if (a_neg) a_abs = -a_abs;
      su_den_in = {a_abs[COEF_W-1:0], 1'b0};
      nb     = -(NUMW'(sq_side[NS].coef_b) <<< FRAC_BITS);
      sx     = $signed(NUMW'(sq_root[NS]));
      num[0] = nb + sx;
      num[1] = nb - sx;
      for (int l = 0; l < 2; l++) begin
         mag[l]       = num[l][NUMW-1] ? -num[l] : num[l];
         su_n_in[l]   = mag[l][NW-1:0];
         su_neg_in[l] = num[l][NUMW-1] ^ a_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         su_v_ff <= 1'b0;
      end else if (sq_ready[NS]) begin
         su_v_ff <= sq_valid[NS];
      end
      if (sq_ready[NS] && sq_valid[NS]) begin
         su_side_ff <= sq_side[NS];
         su_den_ff  <= su_den_in;
         su_neg_ff  <= su_neg_in;
         su_n_ff    <= su_n_in;
      end
   end

   assign dv_valid[0] = su_v_ff;
   assign dv_side[0]  = su_side_ff;
   assign dv_den[0]   = su_den_ff;
   assign dv_neg[0]   = su_neg_ff;
   assign dv_n[0]     = su_n_ff;
   assign dv_p[0]     = '0;

   for (genvar j = 0; j < NW; j++) begin : g_div
      qrs_div_cell #(.NW(NW)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[j]),
         .in_ready  (dv_ready[j]),
         .in_side   (dv_side[j]),
         .in_den    (dv_den[j]),
         .in_neg    (dv_neg[j]),
         .in_n      (dv_n[j]),
         .in_p      (dv_p[j]),
         .out_valid (dv_valid[j+1]),
         .out_ready (dv_ready[j+1]),
         .out_side  (dv_side[j+1]),
         .out_den   (dv_den[j+1]),
         .out_neg   (dv_neg[j+1]),
         .out_n     (dv_n[j+1]),
         .out_p     (dv_p[j+1])
      );
   end

   // output register: sign, saturation, special cases
   logic                       o_v_ff;
   logic signed [ROOT_W-1:0]   o_r_ff [0:1];
   logic signed [ROOT_W-1:0]   o_r_in [0:1];
   logic signed [DISC_W-1:0]   o_disc_ff;
   logic [1:0]                 o_st_ff;
   logic signed [EW-1:0]       qv [0:1];

   assign dv_ready[NW] = !o_v_ff || rsp_ready;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         qv[l] = $signed(EW'(dv_n[NW][l]));
         if (dv_neg[NW][l]) qv[l] = -qv[l];
         if (qv[l] > EW'(ROOT_MAX)) begin
            o_r_in[l] = ROOT_MAX;
         end else if (qv[l] < EW'(ROOT_MIN)) begin
            o_r_in[l] = ROOT_MIN;
         end else begin
            o_r_in[l] = qv[l][ROOT_W-1:0];
         end
         if (dv_side[NW].status == ST_NONE || dv_side[NW].status == ST_NOTQ) begin
            o_r_in[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (dv_ready[NW]) begin
         o_v_ff <= dv_valid[NW];
      end
      if (dv_ready[NW] && dv_valid[NW]) begin
         o_r_ff[0] <= o_r_in[0];
         o_r_ff[1] <= o_r_in[1];
         o_disc_ff <= dv_side[NW].disc;
         o_st_ff   <= dv_side[NW].status;
      end
   end

   assign rsp_valid        = o_v_ff;
   assign rsp_root_plus    = o_r_ff[0];
   assign rsp_root_minus   = o_r_ff[1];
   assign rsp_discriminant = o_disc_ff;
   assign rsp_root_status  = o_st_ff;

endmodule

`default_nettype wire
